>>> sv/tqfl_pkg.sv
// ---------------------------------------------------------------------------
// tqfl_pkg: shared types and constants for the tile quadtree lookup
// Payload structs for the command and result channels, register indexes
// and the level offset pattern of the packed presence map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqfl_pkg;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic REG_BASE_SPLIT  = 1'b0;
  localparam logic REG_LEVEL_COUNT = 1'b1;

  // widths of the configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  // level k starts at 2*(4^k-1)/3, which is binary "10" repeated k times
  localparam logic [31:0] LEVEL_BASE_PAT = 32'hAAAA_AAAA;

  typedef struct packed {
    logic              command;
    logic signed [3:0] level;
    logic [7:0]        col;
    logic [6:0]        row;
  } in_t;

  typedef struct packed {
    logic       found;
    logic       duplicate;
    logic [2:0] tile_level;
    logic [7:0] tile_col;
    logic [6:0] tile_row;
    logic [2:0] level_gap;
    logic [6:0] sub_col;
    logic [6:0] sub_row;
  } out_t;

endpackage

>>> sv/tqfl_ram.sv
// ---------------------------------------------------------------------------
// tqfl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqfl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/tile_quadtree_fallback_lookup_top.sv
// ---------------------------------------------------------------------------
// tile_quadtree_fallback_lookup_top: quadtree tile presence map with
// deepest-ancestor fallback lookup
// Inserts mark tiles in a packed one-bit presence memory; lookups walk from
// the root level down to the requested level and report the deepest tile.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its single
// result shows on out_data for exactly one cycle with out_valid high; the
// receiver cannot stall it. After reset the block first clears the
// 2*(4^MAX_LEVELS-1)/3 presence bits (43690 for eight levels), one bit
// per cycle, and holds busy high meanwhile. An insert passes the check
// and insert-wait states before busy drops, and any command that fails
// its range check goes back to idle from the check state. A lookup at
// absolute level L reads the presence memory once per level from the
// root down to L, each read returning in the next cycle. Configuration
// writes take effect at once, so make them only while no command is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_quadtree_fallback_lookup_top #(
  parameter int MAX_LEVELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  tqfl_pkg::in_t                       in_data,
  // result channel
  output logic                                out_valid,
  output tqfl_pkg::out_t                      out_data,
  // configuration port
  input  logic                                cfg_we,
  input  logic [tqfl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tqfl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int          MAP_BITS = (2 * ((1 << (2 * MAX_LEVELS)) - 1)) / 3;
  localparam int          MAP_AW   = $clog2(MAP_BITS);
  localparam logic [3:0]  MAX_LV   = 4'(MAX_LEVELS);
  localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(MAP_BITS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_INS_WAIT,
    S_WALK
  } state_t;

  state_t              state_r;
  logic [MAP_AW-1:0]   clr_r;
  logic                out_valid_r;
  tqfl_pkg::out_t      out_data_r;

  // registered command
  logic                cmd_r;
  logic signed [4:0]   abs_r;
  logic [7:0]          col_r;
  logic [6:0]          row_r;

  // walk state
  logic [3:0]          iss_k_r;
  logic [3:0]          best_r;
  logic                any_r;
  logic [MAP_AW-1:0]   ins_addr_r;

  // configuration
  logic [2:0]          base_split_r;
  logic [3:0]          level_count_r;

  // memory ports
  logic                mem_we;
  logic [MAP_AW-1:0]   mem_waddr;
  logic [0:0]          mem_wdata;
  logic [MAP_AW-1:0]   mem_raddr;
  logic [0:0]          mem_rdata;

  // bit index of the ancestor at level k of tile (c, r) at level lv
  function automatic logic [MAP_AW-1:0] addr_of(input logic [3:0] k,
                                                input logic [3:0] lv,
                                                input logic [7:0] c,
                                                input logic [6:0] r);
    logic [3:0]  sh;
    logic [31:0] base;
    logic [31:0] row_part;
    logic [31:0] col_part;
    logic [31:0] sum;
    sh       = lv - k;
    base     = tqfl_pkg::LEVEL_BASE_PAT & ((32'd1 << {k, 1'b0}) - 32'd1);
    row_part = {25'd0, r >> sh} << (k + 4'd1);
    col_part = {24'd0, c >> sh};
    sum      = base + row_part + col_part;
    return sum[MAP_AW-1:0];
  endfunction

  // range checks on the registered command
  logic [3:0] lv;
  logic [3:0] lkp_limit;
  logic       grid_ok;
  logic       ins_ok;
  logic       lkp_ok;
  logic       hit;

  assign lv        = abs_r[3:0];
  assign lkp_limit = (level_count_r < MAX_LV) ? level_count_r : MAX_LV;
  assign grid_ok   = ((col_r >> ({1'b0, lv} + 5'd1)) == 8'd0) && ((row_r >> lv) == 7'd0);
  assign ins_ok    = !abs_r[4] && (lv < MAX_LV) && grid_ok;
  assign lkp_ok    = !abs_r[4] && (lv < lkp_limit) && grid_ok;
  assign hit       = mem_rdata[0];

  // result of a finished walk
  logic       fin_any;
  logic [3:0] fin_best;
  logic [3:0] fin_gap;
  logic [7:0] col_mask;
  logic [6:0] row_mask;

  assign fin_any  = any_r | hit;
  assign fin_best = hit ? iss_k_r : best_r;
  assign fin_gap  = lv - fin_best;
  assign col_mask = (8'd1 << fin_gap) - 8'd1;
  assign row_mask = (7'd1 << fin_gap) - 7'd1;

  // result produced in the current state
  logic           res_fire;
  tqfl_pkg::out_t res_data;

  always_comb begin
    res_fire = 1'b0;
    res_data = '0;
    unique case (state_r)
      S_CHECK: begin
        if (!(cmd_r == tqfl_pkg::CMD_INSERT && ins_ok) &&
            !(cmd_r == tqfl_pkg::CMD_LOOKUP && lkp_ok)) begin
          // rejected command: all-zero result
          res_fire = 1'b1;
        end
      end
      S_INS_WAIT: begin
        res_fire            = 1'b1;
        res_data.found      = !hit;
        res_data.duplicate  = hit;
        res_data.tile_level = lv[2:0];
        res_data.tile_col   = col_r;
        res_data.tile_row   = row_r;
      end
      S_WALK: begin
        if (iss_k_r == lv) begin
          res_fire = 1'b1;
          if (fin_any) begin
            res_data.found      = 1'b1;
            res_data.tile_level = fin_best[2:0];
            res_data.tile_col   = col_r >> fin_gap;
            res_data.tile_row   = row_r >> fin_gap;
            res_data.level_gap  = fin_gap[2:0];
            res_data.sub_col    = 7'(col_r & col_mask);
            res_data.sub_row    = row_r & row_mask;
          end
        end
      end
      S_CLEAR, S_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  // read address select
  always_comb begin
    mem_raddr = addr_of(iss_k_r + 4'd1, lv, col_r, row_r);
    unique case (state_r)
      S_CHECK: begin
        if (cmd_r == tqfl_pkg::CMD_INSERT) begin
          mem_raddr = addr_of(lv, lv, col_r, row_r);
        end else begin
          mem_raddr = addr_of(4'd0, lv, col_r, row_r);
        end
      end
      S_CLEAR, S_IDLE, S_INS_WAIT, S_WALK: begin
      end
      default: begin
      end
    endcase
  end

  // write port: clearing pass or insert of a new tile
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins_addr_r;
    mem_wdata = 1'b1;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = 1'b0;
    end else if (state_r == S_INS_WAIT && !hit) begin
      mem_we = 1'b1;
    end
  end

  tqfl_ram #(
    .WIDTH (1),
    .DEPTH (MAP_BITS)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_split_r  <= 3'd0;
      level_count_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tqfl_pkg::REG_BASE_SPLIT:  base_split_r  <= cfg_wdata[2:0];
        tqfl_pkg::REG_LEVEL_COUNT: level_count_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_fire;
      if (res_fire) begin
        out_data_r <= res_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + MAP_AW'(1);
          if (clr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_data.command;
            abs_r   <= {in_data.level[3], in_data.level} + {2'b00, base_split_r};
            col_r   <= in_data.col;
            row_r   <= in_data.row;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          ins_addr_r <= mem_raddr;
          iss_k_r    <= 4'd0;
          any_r      <= 1'b0;
          best_r     <= 4'd0;
          if (cmd_r == tqfl_pkg::CMD_INSERT && ins_ok) begin
            state_r <= S_INS_WAIT;
          end else if (cmd_r == tqfl_pkg::CMD_LOOKUP && lkp_ok) begin
            state_r <= S_WALK;
          end else begin
            // rejected command: all-zero result
            state_r <= S_IDLE;
          end
        end
        S_INS_WAIT: begin
          state_r <= S_IDLE;
        end
        S_WALK: begin
          if (hit) begin
            any_r  <= 1'b1;
            best_r <= iss_k_r;
          end
          if (iss_k_r == lv) begin
            state_r <= S_IDLE;
          end else begin
            iss_k_r <= iss_k_r + 4'd1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one result per command: never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer did not start work");

  // found and duplicate exclude each other
  a_found_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.duplicate))
    else $error("result flags both found and duplicate");

  // a duplicate insert result carries no subrectangle
  a_dup_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.duplicate) |->
      (out_data.level_gap == 3'd0 && out_data.sub_col == 7'd0 && out_data.sub_row == 7'd0))
    else $error("duplicate insert reported a subrectangle");

endmodule

>>> tb/sv/tile_quadtree_fallback_lookup_top_tb.sv
// ---------------------------------------------------------------------------
// tile_quadtree_fallback_lookup_top_tb: self-checking bench for the quadtree
// tile presence map
// Drives insert and lookup commands across several register settings and
// idle patterns. A scoreboard keeps its own copy of the presence map,
// computes the expected ancestor tile and subrect for each transfer, and
// compares every result field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_quadtree_fallback_lookup_top_tb;

  localparam int MAX_LEVELS = 8;
  localparam int MAP_BITS   = (2 * ((1 << (2 * MAX_LEVELS)) - 1)) / 3;
  localparam int SETTLE_CYCLES = 12;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  tqfl_pkg::in_t                   in_data;
  logic                            out_valid;
  tqfl_pkg::out_t                  out_data;
  logic                            cfg_we;
  logic [tqfl_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [tqfl_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // tile address remembered for lookups that descend below it
  typedef struct {
    int lv;
    int col;
    int row;
  } tile_addr_t;

  // presence map mirror and queue of pending results
  class tile_map_scoreboard;
    bit             present [MAP_BITS];
    int             split_reg;
    int             count_reg;
    tqfl_pkg::out_t pending_q[$];
    int             fail_count;
    int             n_insert;
    int             n_dup;
    int             n_lookup;
    int             n_hit;
    int             n_fallback;
    int             n_zero;

    function new();
      split_reg  = 0;
      count_reg  = 1;
      fail_count = 0;
      n_insert   = 0;
      n_dup      = 0;
      n_lookup   = 0;
      n_hit      = 0;
      n_fallback = 0;
      n_zero     = 0;
    endfunction

    function void set_reg(logic idx, int val);
      if (idx == tqfl_pkg::REG_BASE_SPLIT) split_reg = val & 7;
      else count_reg = val & 15;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // first bit of a level in the packed map
    function int level_offset(int lv);
      return (2 * ((1 << (2 * lv)) - 1)) / 3;
    endfunction

    // expected result of one command; inserts update the map
    function tqfl_pkg::out_t compute_result(tqfl_pkg::in_t x);
      tqfl_pkg::out_t r;
      int   rel;
      int   abs_lv;
      int   lim;
      int   idx;
      int   k;
      int   best;
      int   gap;
      bit   any;
      r      = '0;
      rel    = $signed(x.level);
      abs_lv = rel + split_reg;
      any    = 1'b0;
      best   = 0;
      if (x.command == tqfl_pkg::CMD_INSERT) begin
        n_insert++;
        if (abs_lv < 0 || abs_lv >= MAX_LEVELS || x.col >= (2 << abs_lv) ||
            x.row >= (1 << abs_lv)) begin
          n_zero++;
          return r;
        end
        idx = level_offset(abs_lv) + x.row * (2 << abs_lv) + x.col;
        if (present[idx]) begin
          r.duplicate = 1'b1;
          n_dup++;
        end else begin
          present[idx] = 1'b1;
          r.found = 1'b1;
        end
        r.tile_level = abs_lv[2:0];
        r.tile_col   = x.col;
        r.tile_row   = x.row;
        return r;
      end
      n_lookup++;
      lim = (count_reg < MAX_LEVELS) ? count_reg : MAX_LEVELS;
      if (abs_lv < 0 || abs_lv >= lim || x.col >= (2 << abs_lv) ||
          x.row >= (1 << abs_lv)) begin
        n_zero++;
        return r;
      end
      // walk from the roots down, keep the deepest present ancestor
      for (k = 0; k <= abs_lv; k++) begin
        idx = level_offset(k) + (x.row >> (abs_lv - k)) * (2 << k) +
              (x.col >> (abs_lv - k));
        if (present[idx]) begin
          any  = 1'b1;
          best = k;
        end
      end
      if (!any) begin
        n_zero++;
        return r;
      end
      gap          = abs_lv - best;
      r.found      = 1'b1;
      r.tile_level = best[2:0];
      r.tile_col   = x.col >> gap;
      r.tile_row   = x.row >> gap;
      r.level_gap  = gap[2:0];
      r.sub_col    = 7'(x.col & ((1 << gap) - 1));
      r.sub_row    = 7'(x.row & ((1 << gap) - 1));
      n_hit++;
      if (gap > 0) n_fallback++;
      return r;
    endfunction

    function void note_command(tqfl_pkg::in_t x);
      pending_q.push_back(compute_result(x));
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      fail_count++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(tqfl_pkg::out_t got);
      tqfl_pkg::out_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", got));
        return;
      end
      want = pending_q.pop_front();
      check_field("found", 8'(got.found), 8'(want.found));
      check_field("duplicate", 8'(got.duplicate), 8'(want.duplicate));
      check_field("tile_level", 8'(got.tile_level), 8'(want.tile_level));
      check_field("tile_col", got.tile_col, want.tile_col);
      check_field("tile_row", 8'(got.tile_row), 8'(want.tile_row));
      check_field("level_gap", 8'(got.level_gap), 8'(want.level_gap));
      check_field("sub_col", 8'(got.sub_col), 8'(want.sub_col));
      check_field("sub_row", 8'(got.sub_row), 8'(want.sub_row));
    endtask
  endclass

  tile_map_scoreboard sb;
  tile_addr_t         stored_tiles[$];
  int                 sender_idle_pct;
  int                 n_settings;

  tile_quadtree_fallback_lookup_top #(
    .MAX_LEVELS(MAX_LEVELS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_data);
  end

  // hold one command until the block takes it, then maybe go idle
  task automatic send_command(tqfl_pkg::in_t x);
    start   <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(x);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic send_fields(logic cmd, int lvl, int col, int row);
    tqfl_pkg::in_t x;
    x.command = cmd;
    x.level   = 4'(lvl);
    x.col     = 8'(col);
    x.row     = 7'(row);
    send_command(x);
  endtask

  // wait for every pending result, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 4'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    n_settings++;
  endtask

  // one random command: mostly inserts and lookups under known tiles
  task automatic make_random_command(output tqfl_pkg::in_t x);
    int         lim;
    int         lv;
    int         d;
    int         pick;
    tile_addr_t t;
    lim  = (sb.count_reg < MAX_LEVELS) ? sb.count_reg : MAX_LEVELS;
    pick = $urandom_range(99);
    if (pick < 65 && pick >= 30 && stored_tiles.size() != 0) begin
      t = stored_tiles[$urandom_range(stored_tiles.size() - 1)];
      if (t.lv >= lim) pick = 70;
    end
    if (pick < 30) begin
      // insert, biased toward shallow levels, sometimes above level count
      if ($urandom_range(3) == 0) lv = $urandom_range(MAX_LEVELS - 1);
      else lv = $urandom_range($urandom_range(lim - 1));
      x.command = tqfl_pkg::CMD_INSERT;
      x.level   = 4'(lv - sb.split_reg);
      x.col     = 8'($urandom_range((2 << lv) - 1));
      x.row     = 7'($urandom_range((1 << lv) - 1));
      t.lv  = lv;
      t.col = int'(x.col);
      t.row = int'(x.row);
      stored_tiles.push_back(t);
    end else if (pick < 65 && stored_tiles.size() != 0) begin
      // lookup somewhere under a stored tile
      lv = $urandom_range(lim - 1, t.lv);
      d  = lv - t.lv;
      x.command = tqfl_pkg::CMD_LOOKUP;
      x.level   = 4'(lv - sb.split_reg);
      x.col     = 8'((t.col << d) | $urandom_range((1 << d) - 1));
      x.row     = 7'((t.row << d) | $urandom_range((1 << d) - 1));
    end else if (pick < 80) begin
      // lookup anywhere in range
      lv = $urandom_range(lim - 1);
      x.command = tqfl_pkg::CMD_LOOKUP;
      x.level   = 4'(lv - sb.split_reg);
      x.col     = 8'($urandom_range((2 << lv) - 1));
      x.row     = 7'($urandom_range((1 << lv) - 1));
    end else begin
      // raw fields, mostly out of range
      x.command = 1'($urandom_range(1));
      x.level   = 4'($urandom_range(15));
      x.col     = 8'($urandom_range(255));
      x.row     = 7'($urandom_range(127));
    end
  endtask

  // run limit
  initial begin
    #1500000;
    $display("[tile_quadtree_fallback_lookup_top] ERROR");
    $finish;
  end

  initial begin
    int            split_list [6];
    int            count_list [6];
    int            idle_modes [4];
    int            seg;
    int            i;
    tqfl_pkg::in_t x;
    split_list = '{0, 7, 3, 0, 5, 2};
    count_list = '{8, 8, 5, 1, 3, 8};
    idle_modes = '{0, 86, 0, 17};
    sb = new();
    n_settings      = 0;
    sender_idle_pct = 0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, root tile, bounds on each field
    send_fields(tqfl_pkg::CMD_LOOKUP, 0, 0, 0);
    send_fields(tqfl_pkg::CMD_INSERT, 0, 0, 0);
    send_fields(tqfl_pkg::CMD_INSERT, 0, 0, 0);
    send_fields(tqfl_pkg::CMD_LOOKUP, 0, 0, 0);
    send_fields(tqfl_pkg::CMD_LOOKUP, 1, 0, 0);
    send_fields(tqfl_pkg::CMD_INSERT, 5, 63, 31);
    send_fields(tqfl_pkg::CMD_INSERT, 0, 2, 0);
    send_fields(tqfl_pkg::CMD_INSERT, 0, 0, 1);
    send_fields(tqfl_pkg::CMD_INSERT, -8, 0, 0);
    write_reg(tqfl_pkg::REG_BASE_SPLIT, 0);
    write_reg(tqfl_pkg::REG_LEVEL_COUNT, 8);
    send_fields(tqfl_pkg::CMD_INSERT, 7, 255, 127);
    send_fields(tqfl_pkg::CMD_LOOKUP, 7, 255, 127);
    send_fields(tqfl_pkg::CMD_LOOKUP, 7, 127, 127);
    send_fields(tqfl_pkg::CMD_LOOKUP, 6, 100, 60);
    send_fields(tqfl_pkg::CMD_INSERT, 3, 5, 2);
    send_fields(tqfl_pkg::CMD_LOOKUP, 6, 47, 21);
    send_fields(tqfl_pkg::CMD_LOOKUP, 5, 63, 31);
    send_fields(tqfl_pkg::CMD_LOOKUP, -1, 0, 0);
    send_fields(tqfl_pkg::CMD_LOOKUP, 2, 8, 0);
    send_fields(tqfl_pkg::CMD_LOOKUP, 2, 0, 4);
    write_reg(tqfl_pkg::REG_BASE_SPLIT, 7);
    send_fields(tqfl_pkg::CMD_INSERT, 7, 0, 0);
    send_fields(tqfl_pkg::CMD_INSERT, -7, 1, 0);
    send_fields(tqfl_pkg::CMD_LOOKUP, 0, 200, 100);
    send_fields(tqfl_pkg::CMD_LOOKUP, -8, 0, 0);

    // random segments over several register settings and idle patterns
    for (seg = 0; seg < 6; seg++) begin
      write_reg(tqfl_pkg::REG_BASE_SPLIT, split_list[seg]);
      write_reg(tqfl_pkg::REG_LEVEL_COUNT, count_list[seg]);
      sender_idle_pct = idle_modes[seg % 4];
      for (i = 0; i < 317; i++) begin
        make_random_command(x);
        send_command(x);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d inserts (%0d repeats), %0d lookups (%0d hits, %0d from ancestors)",
             sb.n_insert, sb.n_dup, sb.n_lookup, sb.n_hit, sb.n_fallback);
    $display("%0d all-zero results over %0d register writes, %0d mismatches",
             sb.n_zero, n_settings, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("[tile_quadtree_fallback_lookup_top] OK");
    end else begin
      $display("[tile_quadtree_fallback_lookup_top] ERROR");
    end
    $finish;
  end

endmodule
